[src/i2crbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crbm_pkg
// shared types and constants of the i2c single-byte register master
// ----------------------------------------------------------------------------
package i2crbm_pkg;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned SlaveW   = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned DivW     = 16;
  localparam int unsigned CfgIdxW  = 1;

  // stream widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = OpW;
  localparam int unsigned OutDataW = 16;

  // operation codes on the input tuser
  localparam logic [OpW-1:0] OpTick  = 2'd0;
  localparam logic [OpW-1:0] OpWrite = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSclHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSclLow  = 1'b1;

  localparam logic [DivW-1:0] DivReset = 16'd75;

  // transfer status codes
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StAddrWNak = 3'd1;
  localparam logic [StatusW-1:0] StRegNak   = 3'd2;
  localparam logic [StatusW-1:0] StDataNak  = 3'd3;
  localparam logic [StatusW-1:0] StAddrRNak = 3'd4;

  // decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KindTick,
    KindWrite,
    KindRead
  } cmd_kind_e;

  // one classified tick as it waits in the queue
  typedef struct packed {
    cmd_kind_e           kind;
    logic [SlaveW-1:0]   slave_addr;
    logic [ByteW-1:0]    reg_addr;
    logic [ByteW-1:0]    write_data;
    logic                sda_in;
  } q_entry_t;

  // one result word
  typedef struct packed {
    logic                scl_drive_low;
    logic                sda_drive_low;
    logic                busy_res;
    logic                done_res;
    logic [StatusW-1:0]  status;
    logic [ByteW-1:0]    read_data;
  } res_t;

  // configuration write
  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [DivW-1:0]     data;
  } cfg_wr_t;

endpackage

[src/i2crbm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crbm_front
// takes input words, decodes the operation and pushes them into the queue
// ----------------------------------------------------------------------------
module i2crbm_front (
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [i2crbm_pkg::InDataW-1:0]     in_data_i,
  input  logic [i2crbm_pkg::InUserW-1:0]     in_user_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output i2crbm_pkg::q_entry_t               q_entry_o
);
  import i2crbm_pkg::*;

  cmd_kind_e kind;

  // unused operation code counts as a plain tick
  always_comb begin
    case (in_user_i)
      OpWrite: kind = KindWrite;
      OpRead:  kind = KindRead;
      default: kind = KindTick;
    endcase
  end

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  assign q_entry_o.kind       = kind;
  assign q_entry_o.slave_addr = in_data_i[6:0];
  assign q_entry_o.reg_addr   = in_data_i[14:7];
  assign q_entry_o.write_data = in_data_i[22:15];
  assign q_entry_o.sda_in     = in_data_i[23];

endmodule

[src/i2crbm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crbm_queue
// short fifo of decoded ticks between front and back
// ----------------------------------------------------------------------------
module i2crbm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  i2crbm_pkg::q_entry_t  wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output i2crbm_pkg::q_entry_t  rdata_o
);
  import i2crbm_pkg::*;

  localparam logic [QPtrW-1:0] LastPtr = QPtrW'(QDepth - 1);
  localparam logic [QCntW-1:0] FullCnt = QCntW'(QDepth);

  q_entry_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[src/i2crbm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crbm_back
// bus sequencer: one step per queued tick, result held in an output register
// ----------------------------------------------------------------------------
module i2crbm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2crbm_pkg::cfg_wr_t   cfg_i,
  input  logic                  q_valid_i,
  input  i2crbm_pkg::q_entry_t  q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2crbm_pkg::res_t      out_res_o
);
  import i2crbm_pkg::*;

  typedef enum logic [3:0] {
    PhIdle,
    PhStart,
    PhBitLow,
    PhBitHigh,
    PhRsLow,
    PhRsHigh,
    PhRsHold,
    PhStopLow,
    PhStopHigh,
    PhDone
  } phase_e;

  typedef enum logic [2:0] {
    BsAddrW,
    BsReg,
    BsData,
    BsAddrR,
    BsRead
  } byte_sel_e;

  localparam logic [3:0] BitAck = 4'd8;

  // state
  phase_e              phase_q, phase_d;
  byte_sel_e           bsel_q, bsel_d;
  logic [3:0]          bidx_q, bidx_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [SlaveW-1:0]   slave_q, slave_d;
  logic [ByteW-1:0]    reg_q, reg_d;
  logic [ByteW-1:0]    data_q, data_d;
  logic                rd_q, rd_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ByteW-1:0]    last_rd_q, last_rd_d;
  logic [DivW-1:0]     scl_hi_q, scl_lo_q;
  logic                out_valid_q;
  res_t                out_res_q, res_d;

  logic                step;
  logic [DivW-1:0]     len;
  logic [DivW:0]       div_inc;
  logic                last;
  logic                bit_sda_low;
  logic                sda;

  assign step    = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o = step;
  assign sda     = q_entry_i.sda_in;

  always_comb begin
    phase_d   = phase_q;
    bsel_d    = bsel_q;
    bidx_d    = bidx_q;
    div_d     = div_q;
    shift_d   = shift_q;
    slave_d   = slave_q;
    reg_d     = reg_q;
    data_d    = data_q;
    rd_d      = rd_q;
    status_d  = status_q;
    last_rd_d = last_rd_q;
    res_d     = '0;
    len       = scl_hi_q;
    div_inc   = '0;
    last      = 1'b0;

    // command taken only while idle, that tick is already the first of start
    if (phase_d == PhIdle && q_entry_i.kind != KindTick) begin
      slave_d = q_entry_i.slave_addr;
      reg_d   = q_entry_i.reg_addr;
      data_d  = q_entry_i.write_data;
      rd_d    = (q_entry_i.kind == KindRead);
      phase_d = PhStart;
      div_d   = '0;
      bidx_d  = '0;
    end

    bit_sda_low = (bidx_d < BitAck) && (bsel_d != BsRead) && !shift_d[~bidx_d[2:0]];

    if (phase_d != PhIdle) begin
      res_d.busy_res = 1'b1;
      case (phase_d)
        PhStart:    res_d.sda_drive_low = 1'b1;
        PhBitLow: begin
          res_d.scl_drive_low = 1'b1;
          res_d.sda_drive_low = bit_sda_low;
        end
        PhBitHigh:  res_d.sda_drive_low = bit_sda_low;
        PhRsLow:    res_d.scl_drive_low = 1'b1;
        PhRsHold:   res_d.sda_drive_low = 1'b1;
        PhStopLow: begin
          res_d.scl_drive_low = 1'b1;
          res_d.sda_drive_low = 1'b1;
        end
        PhStopHigh: res_d.sda_drive_low = 1'b1;
        PhDone: begin
          res_d.done_res = 1'b1;
          last_rd_d      = shift_d;
        end
        default: ;
      endcase

      // half-bit length, zero counts as one tick
      if (phase_d inside {PhBitLow, PhRsLow, PhStopLow}) begin
        len = scl_lo_q;
      end else if (phase_d == PhDone) begin
        len = DivW'(1);
      end else begin
        len = scl_hi_q;
      end
      if (len == '0) begin
        len = DivW'(1);
      end

      div_inc = {1'b0, div_d} + 1'b1;
      last    = (div_inc >= {1'b0, len});
      div_d   = div_inc[DivW-1:0];

      if (last) begin
        div_d = '0;
        case (phase_d)
          PhStart: begin
            bsel_d  = BsAddrW;
            shift_d = {slave_d, 1'b0};
            bidx_d  = '0;
            phase_d = PhBitLow;
          end
          PhBitLow: phase_d = PhBitHigh;
          PhBitHigh: begin
            if (bidx_d < BitAck) begin
              if (bsel_d == BsRead) begin
                shift_d = {shift_d[ByteW-2:0], sda};
              end
              bidx_d  = bidx_d + 1'b1;
              phase_d = PhBitLow;
            end else if (bsel_d == BsRead) begin
              // received byte answered with nack, then stop
              status_d = StOk;
              phase_d  = PhStopLow;
            end else if (sda) begin
              // nack from the slave
              case (bsel_d)
                BsAddrW: status_d = StAddrWNak;
                BsReg:   status_d = StRegNak;
                BsData:  status_d = StDataNak;
                default: status_d = StAddrRNak;
              endcase
              shift_d = '0;
              phase_d = PhStopLow;
            end else begin
              case (bsel_d)
                BsAddrW: begin
                  bsel_d  = BsReg;
                  shift_d = reg_d;
                  bidx_d  = '0;
                  phase_d = PhBitLow;
                end
                BsReg: begin
                  if (rd_d) begin
                    phase_d = PhRsLow;
                  end else begin
                    bsel_d  = BsData;
                    shift_d = data_d;
                    bidx_d  = '0;
                    phase_d = PhBitLow;
                  end
                end
                BsData: begin
                  status_d = StOk;
                  shift_d  = '0;
                  phase_d  = PhStopLow;
                end
                default: begin
                  bsel_d  = BsRead;
                  shift_d = '0;
                  bidx_d  = '0;
                  phase_d = PhBitLow;
                end
              endcase
            end
          end
          PhRsLow:  phase_d = PhRsHigh;
          PhRsHigh: phase_d = PhRsHold;
          PhRsHold: begin
            bsel_d  = BsAddrR;
            shift_d = {slave_d, 1'b1};
            bidx_d  = '0;
            phase_d = PhBitLow;
          end
          PhStopLow:  phase_d = PhStopHigh;
          PhStopHigh: phase_d = PhDone;
          default:    phase_d = PhIdle;
        endcase
      end
    end

    res_d.status    = status_d;
    res_d.read_data = last_rd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bsel_q      <= BsAddrW;
      bidx_q      <= '0;
      div_q       <= '0;
      shift_q     <= '0;
      slave_q     <= '0;
      reg_q       <= '0;
      data_q      <= '0;
      rd_q        <= 1'b0;
      status_q    <= StOk;
      last_rd_q   <= '0;
      scl_hi_q    <= DivReset;
      scl_lo_q    <= DivReset;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CfgSclHigh: scl_hi_q <= cfg_i.data;
          CfgSclLow:  scl_lo_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (step) begin
        phase_q     <= phase_d;
        bsel_q      <= bsel_d;
        bidx_q      <= bidx_d;
        div_q       <= div_d;
        shift_q     <= shift_d;
        slave_q     <= slave_d;
        reg_q       <= reg_d;
        data_q      <= data_d;
        rd_q        <= rd_d;
        status_q    <= status_d;
        last_rd_q   <= last_rd_d;
        out_res_q   <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // the sequencer
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.done_res |-> out_res_q.busy_res)
    else $error("done without busy");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> div_q == '0)
    else $error("divider not cleared in idle");

  a_bidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bidx_q <= BitAck)
    else $error("bit index out of range");

  a_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |=> phase_q == PhDone || phase_q == PhIdle)
    else $error("bad exit from done");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(div_q))
    else $error("sequencer moved without a tick");

endmodule

[src/i2c_register_byte_master_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_byte_master_core
// i2c master doing one single-byte register write or read per command
// ----------------------------------------------------------------------------
// each input word is one bus clock tick: tuser carries the operation (tick,
// write, read), tdata the target address, register, write byte and the sampled
// sda level. each input word gives exactly one output word with the scl and sda
// pull-down drives, busy, a done pulse, the status of the last transfer and
// the last read byte.
// a write runs start, addr+w, register, data, stop; a read runs start, addr+w,
// register, repeated start, addr+r, one byte answered with nack, stop. a nack
// from the slave goes to stop with an error status and read byte 0. commands
// arriving while busy are ignored.
// the config channel writes the scl high count (index 0) and low count
// (index 1); both reset to 75 ticks. they are to be written only while idle;
// the block itself does not enforce this. an accepted word is stored in the
// queue, then the sequencer step puts its result into the output register.
// throughput: one word per cycle while the output is not stalled, set by the single-step sequencer.
// reset: sequencer idle, queue and output register empty, status 0.
// a stalled output holds its word; the queue keeps taking input until full,
// then tready drops.
// ----------------------------------------------------------------------------
module i2c_register_byte_master_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [6:0] slave_addr, [14:7] reg_addr, [22:15] write_data, [23] sda_in
  input  logic [i2crbm_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] operation
  input  logic [i2crbm_pkg::InUserW-1:0]      s_axis_tuser,
  // result words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] scl_drive_low, [1] sda_drive_low, [2] busy_res, [3] done_res,
  // [6:4] status, [14:7] read_data, [15] zero
  output logic [i2crbm_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [i2crbm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [i2crbm_pkg::DivW-1:0]         cfg_data_i
);
  import i2crbm_pkg::*;

  q_entry_t  push_entry, pop_entry;
  logic      q_push, q_full, q_pop, q_valid;
  cfg_wr_t   cfg_wr;
  res_t      res;

  // config always taken, ready tied high
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // front: handshake and operation decode
  i2crbm_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  // decoupling queue
  i2crbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (pop_entry)
  );

  // back: bus sequencer and output register
  i2crbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // pack result word, lowest field first
  assign m_axis_tdata = {1'b0, res.read_data, res.status, res.done_res,
                         res.busy_res, res.sda_drive_low, res.scl_drive_low};

endmodule
